/* rtl/core/obb_pkg.sv */
// Shared constants for the oriented-box separating-axis overlap pipeline.
// No dependencies.
package obb_pkg;

  localparam int unsigned FieldW       = 54;
  localparam int unsigned CompBitsDef  = 18;
  localparam int unsigned NumFields    = 10;
  localparam int unsigned NumAxes      = 15;
  localparam int unsigned RoundShift   = 16;

endpackage

/* rtl/core/obb_rot.sv */
// Rotation matrix and center projection: unpack, multiply, sum and round.
// Three register stages advanced together by adv_i. Depends on obb_pkg.
module obb_rot #(
  parameter int unsigned CB = obb_pkg::CompBitsDef
) (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic [obb_pkg::FieldW-1:0]     fields_i [obb_pkg::NumFields],
  output logic signed [2*CB-15:0]        r_o      [3][3],
  output logic        [2*CB-15:0]        ar_o     [3][3],
  output logic signed [2*CB-14:0]        t_o      [3],
  output logic        [CB-2:0]           ha_o     [3],
  output logic        [CB-2:0]           hb_o     [3]
);

  localparam int unsigned RW = 2 * CB - 14;
  localparam int unsigned TW = 2 * CB - 13;
  localparam int unsigned SW = 2 * CB + 2;
  localparam int unsigned DW = 2 * CB + 3;

  logic signed [CB-1:0]   aa_q [3][3];
  logic signed [CB-1:0]   ba_q [3][3];
  logic signed [CB:0]     d_q  [3];
  logic        [CB-2:0]   ha_a_q [3];
  logic        [CB-2:0]   hb_a_q [3];

  logic signed [2*CB-1:0] pr_q [3][3][3];
  logic signed [2*CB:0]   pd_q [3][3];
  logic        [CB-2:0]   ha_b_q [3];
  logic        [CB-2:0]   hb_b_q [3];

  logic signed [RW-1:0]   r_d  [3][3];
  logic        [RW-1:0]   ar_d [3][3];
  logic signed [TW-1:0]   t_d  [3];
  logic signed [RW-1:0]   r_q  [3][3];
  logic        [RW-1:0]   ar_q [3][3];
  logic signed [TW-1:0]   t_q  [3];
  logic        [CB-2:0]   ha_c_q [3];
  logic        [CB-2:0]   hb_c_q [3];

  logic signed [CB-1:0]   ac_w [3];
  logic signed [CB-1:0]   bc_w [3];
  logic        [CB-1:0]   ha_w [3];
  logic        [CB-1:0]   hb_w [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ac_w[k] = $signed(fields_i[0][k*CB +: CB]);
      bc_w[k] = $signed(fields_i[5][k*CB +: CB]);
      ha_w[k] = fields_i[4][k*CB +: CB];
      hb_w[k] = fields_i[9][k*CB +: CB];
    end
  end

  // Stage A: unpack, offset, clamp
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          aa_q[i][k] <= $signed(fields_i[1+i][k*CB +: CB]);
          ba_q[i][k] <= $signed(fields_i[6+i][k*CB +: CB]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        d_q[k]    <= (CB+1)'(bc_w[k]) - (CB+1)'(ac_w[k]);
        ha_a_q[k] <= ha_w[k][CB-1] ? '0 : ha_w[k][CB-2:0];
        hb_a_q[k] <= hb_w[k][CB-1] ? '0 : hb_w[k][CB-2:0];
      end
    end
  end

  // Stage B: products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          pd_q[i][k] <= (2*CB+1)'(d_q[k]) * (2*CB+1)'(aa_q[i][k]);
          for (int j = 0; j < 3; j++) begin
            pr_q[i][j][k] <= (2*CB)'(aa_q[i][k]) * (2*CB)'(ba_q[j][k]);
          end
        end
      end
      ha_b_q <= ha_a_q;
      hb_b_q <= hb_a_q;
    end
  end

  // Stage C: sum and round half away from zero
  always_comb begin
    logic signed [SW-1:0] s;
    logic        [SW-1:0] sa;
    logic        [SW-1:0] m;
    logic signed [SW-1:0] rr;
    logic signed [DW-1:0] ts;
    logic        [DW-1:0] tsa;
    logic        [DW-1:0] tm;
    logic signed [DW-1:0] tr;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s  = SW'(pr_q[i][j][0]) + SW'(pr_q[i][j][1]) + SW'(pr_q[i][j][2]);
        sa = s[SW-1] ? SW'(-s) : SW'(s);
        m  = (sa + SW'(32768)) >> obb_pkg::RoundShift;
        rr = s[SW-1] ? -$signed(m) : $signed(m);
        r_d[i][j]  = rr[RW-1:0];
        ar_d[i][j] = m[RW-1:0] + RW'(1);
      end
      ts  = DW'(pd_q[i][0]) + DW'(pd_q[i][1]) + DW'(pd_q[i][2]);
      tsa = ts[DW-1] ? DW'(-ts) : DW'(ts);
      tm  = (tsa + DW'(32768)) >> obb_pkg::RoundShift;
      tr  = ts[DW-1] ? -$signed(tm) : $signed(tm);
      t_d[i] = tr[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q    <= r_d;
      ar_q   <= ar_d;
      t_q    <= t_d;
      ha_c_q <= ha_b_q;
      hb_c_q <= hb_b_q;
    end
  end

  assign r_o  = r_q;
  assign ar_o = ar_q;
  assign t_o  = t_q;
  assign ha_o = ha_c_q;
  assign hb_o = hb_c_q;

endmodule

/* rtl/core/obb_axis.sv */
// Fifteen-axis test: radius and distance products, compares, reduction.
// Three register stages advanced together by adv_i. Depends on obb_pkg.
module obb_axis #(
  parameter int unsigned CB = obb_pkg::CompBitsDef
) (
  input  logic                    clk_i,
  input  logic                    adv_i,
  input  logic signed [2*CB-15:0] r_i  [3][3],
  input  logic        [2*CB-15:0] ar_i [3][3],
  input  logic signed [2*CB-14:0] t_i  [3],
  input  logic        [CB-2:0]    ha_i [3],
  input  logic        [CB-2:0]    hb_i [3],
  output logic                    overlap_o
);

  localparam int unsigned RW  = 2 * CB - 14;
  localparam int unsigned TW  = 2 * CB - 13;
  localparam int unsigned PAW = CB - 1 + RW;
  localparam int unsigned PTW = TW + RW;
  localparam int unsigned SW  = PTW + 3;

  logic        [PAW-1:0] pa_q [3][3][3];
  logic        [PAW-1:0] pb_q [3][3][3];
  logic signed [PTW-1:0] pt_q [3][3][3];
  logic signed [TW-1:0]  t_q  [3];
  logic        [CB-2:0]  ha_q [3];
  logic        [CB-2:0]  hb_q [3];

  logic [obb_pkg::NumAxes-1:0] sep_d;
  logic [obb_pkg::NumAxes-1:0] sep_q;
  logic                        overlap_q;

  // Stage D: products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int j = 0; j < 3; j++) begin
            pa_q[a][b][j] <= PAW'(ha_i[a]) * PAW'(ar_i[b][j]);
            pb_q[a][b][j] <= PAW'(hb_i[b]) * PAW'(ar_i[a][j]);
            pt_q[a][b][j] <= PTW'(t_i[a]) * PTW'(r_i[b][j]);
          end
        end
      end
      t_q  <= t_i;
      ha_q <= ha_i;
      hb_q <= hb_i;
    end
  end

  // Stage E: compare each axis
  for (genvar i = 0; i < 3; i++) begin : g_face
    logic [SW-1:0]        ta_w;
    logic [SW-1:0]        fa_rad_w;
    logic signed [SW-1:0] fb_dist_w;
    logic [SW-1:0]        fb_abs_w;
    logic [SW-1:0]        fb_rad_w;
    always_comb begin
      ta_w = t_q[i][TW-1] ? SW'({SW'(-t_q[i]), 16'b0}) : SW'({SW'(t_q[i]), 16'b0});
      fa_rad_w = SW'({ha_q[i], 16'b0}) + SW'(pb_q[i][0][0]) + SW'(pb_q[i][1][1])
               + SW'(pb_q[i][2][2]);
      fb_dist_w = SW'(pt_q[0][0][i]) + SW'(pt_q[1][1][i]) + SW'(pt_q[2][2][i]);
      fb_abs_w  = fb_dist_w[SW-1] ? SW'(-fb_dist_w) : SW'(fb_dist_w);
      fb_rad_w  = SW'({hb_q[i], 16'b0}) + SW'(pa_q[0][0][i]) + SW'(pa_q[1][1][i])
                + SW'(pa_q[2][2][i]);
    end
    assign sep_d[i]     = ta_w > fa_rad_w;
    assign sep_d[3 + i] = fb_abs_w > fb_rad_w;
  end

  for (genvar i = 0; i < 3; i++) begin : g_edge_i
    for (genvar j = 0; j < 3; j++) begin : g_edge_j
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      logic [SW-1:0]        rad_w;
      logic signed [SW-1:0] dist_w;
      logic [SW-1:0]        abs_w;
      always_comb begin
        rad_w  = SW'(pa_q[I1][I2][j]) + SW'(pa_q[I2][I1][j])
               + SW'(pb_q[i][J1][J2]) + SW'(pb_q[i][J2][J1]);
        dist_w = SW'(pt_q[I1][I2][j]) - SW'(pt_q[I2][I1][j]);
        abs_w  = dist_w[SW-1] ? SW'(-dist_w) : SW'(dist_w);
      end
      assign sep_d[6 + 3*i + j] = abs_w > rad_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sep_q <= sep_d;
    end
  end

  // Stage F: no separating axis means overlap
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      overlap_q <= ~|sep_q;
    end
  end

  assign overlap_o = overlap_q;

endmodule

/* rtl/core/obb_overlap_separating_axis.sv */
// Oriented-box overlap by the 15-axis separating test, six register stages.
// Throughput: one box pair per cycle; a stall at the output freezes all stages.
// Reset clears the stage valid bits only; the pipeline then takes items at once.
// Depends on obb_pkg, obb_rot and obb_axis.
module obb_overlap_separating_axis #(
  parameter int unsigned COMPONENT_BITS = obb_pkg::CompBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [obb_pkg::FieldW-1:0]  a_center_i,
  input  logic [obb_pkg::FieldW-1:0]  a_axis_x_i,
  input  logic [obb_pkg::FieldW-1:0]  a_axis_y_i,
  input  logic [obb_pkg::FieldW-1:0]  a_axis_z_i,
  input  logic [obb_pkg::FieldW-1:0]  a_half_sizes_i,
  input  logic [obb_pkg::FieldW-1:0]  b_center_i,
  input  logic [obb_pkg::FieldW-1:0]  b_axis_x_i,
  input  logic [obb_pkg::FieldW-1:0]  b_axis_y_i,
  input  logic [obb_pkg::FieldW-1:0]  b_axis_z_i,
  input  logic [obb_pkg::FieldW-1:0]  b_half_sizes_i,
  output logic                        overlap_valid_o,
  input  logic                        overlap_ready_i,
  output logic                        overlap_o
);

  localparam int unsigned CB     = COMPONENT_BITS;
  localparam int unsigned Stages = 6;

  logic                       adv;
  logic [Stages-1:0]          vld_q;
  logic [Stages-1:0]          vld_d;
  logic [obb_pkg::FieldW-1:0] fields [obb_pkg::NumFields];

  logic signed [2*CB-15:0] r_w  [3][3];
  logic        [2*CB-15:0] ar_w [3][3];
  logic signed [2*CB-14:0] t_w  [3];
  logic        [CB-2:0]    ha_w [3];
  logic        [CB-2:0]    hb_w [3];

  assign fields[0] = a_center_i;
  assign fields[1] = a_axis_x_i;
  assign fields[2] = a_axis_y_i;
  assign fields[3] = a_axis_z_i;
  assign fields[4] = a_half_sizes_i;
  assign fields[5] = b_center_i;
  assign fields[6] = b_axis_x_i;
  assign fields[7] = b_axis_y_i;
  assign fields[8] = b_axis_z_i;
  assign fields[9] = b_half_sizes_i;

  // advance when the output stage is empty or being drained
  assign adv        = !vld_q[Stages-1] || overlap_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  obb_rot #(.CB(CB)) u_rot (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .fields_i (fields),
    .r_o      (r_w),
    .ar_o     (ar_w),
    .t_o      (t_w),
    .ha_o     (ha_w),
    .hb_o     (hb_w)
  );

  obb_axis #(.CB(CB)) u_axis (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .r_i       (r_w),
    .ar_i      (ar_w),
    .t_i       (t_w),
    .ha_i      (ha_w),
    .hb_i      (hb_w),
    .overlap_o (overlap_o)
  );

  assign overlap_valid_o = vld_q[Stages-1];

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item did not enter first stage");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> overlap_valid_o && !overlap_ready_i)
    else $error("input stalled without output backpressure");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overlap_valid_o && !overlap_ready_i |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_drain_shifts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |=> vld_q[Stages-1:1] == $past(vld_q[Stages-2:0]))
    else $error("valid bits did not advance");

endmodule

/* tb/tb.sv */
// Self-checking testbench for obb_overlap_separating_axis: box pairs go in
// over a valid/ready channel, the overlap bit comes back and is compared with
// a fixed-point separating-axis predictor. Depends on obb_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CB = obb_pkg::CompBitsDef;
  localparam int unsigned WatchLimit = 20000;

  typedef logic [obb_pkg::FieldW-1:0] field_t;
  typedef struct packed {
    field_t ac, aax, aay, aaz, ah, bc, bax, bay, baz, bh;
  } pair_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  pair_t  pair_q = '0;
  logic   overlap_valid_o;
  logic   overlap_ready_i = 1'b0;
  logic   overlap_o;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     mismatches = 0;
  int     idle_cycles = 0;
  bit     overlap_q[$];

  always #4 clk_i = ~clk_i;

  obb_overlap_separating_axis dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a_center_i(pair_q.ac), .a_axis_x_i(pair_q.aax), .a_axis_y_i(pair_q.aay),
    .a_axis_z_i(pair_q.aaz), .a_half_sizes_i(pair_q.ah),
    .b_center_i(pair_q.bc), .b_axis_x_i(pair_q.bax), .b_axis_y_i(pair_q.bay),
    .b_axis_z_i(pair_q.baz), .b_half_sizes_i(pair_q.bh),
    .overlap_valid_o, .overlap_ready_i, .overlap_o
  );

  function automatic longint comp(field_t w, int k);
    logic signed [CB-1:0] c;
    c = w[k*CB +: CB];
    return longint'(c);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint rnd16(longint v);
    longint m;
    m = (abs_l(v) + 32768) / 65536;
    return v < 0 ? -m : m;
  endfunction

  function automatic bit boxes_overlap(pair_t p);
    longint aa[3][3], ba[3][3], ha[3], hb[3], d[3], t[3], r[3][3], ar[3][3];
    longint acc, s, ra, rb, proj;
    int i1, i2, j1, j2;
    bit sep;
    sep = 0;
    for (int k = 0; k < 3; k++) begin
      aa[0][k] = comp(p.aax, k); aa[1][k] = comp(p.aay, k); aa[2][k] = comp(p.aaz, k);
      ba[0][k] = comp(p.bax, k); ba[1][k] = comp(p.bay, k); ba[2][k] = comp(p.baz, k);
      ha[k] = comp(p.ah, k); hb[k] = comp(p.bh, k);
      if (ha[k] < 0) ha[k] = 0;
      if (hb[k] < 0) hb[k] = 0;
      d[k] = comp(p.bc, k) - comp(p.ac, k);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += d[k] * aa[i][k];
      t[i] = rnd16(acc);
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int k = 0; k < 3; k++) s += aa[i][k] * ba[j][k];
        r[i][j] = rnd16(s);
        ar[i][j] = abs_l(r[i][j]) + 1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      ra = ha[i] * 65536;
      rb = hb[0] * ar[i][0] + hb[1] * ar[i][1] + hb[2] * ar[i][2];
      if (abs_l(t[i]) * 65536 > ra + rb) sep = 1;
      ra = ha[0] * ar[0][i] + ha[1] * ar[1][i] + ha[2] * ar[2][i];
      rb = hb[i] * 65536;
      proj = t[0] * r[0][i] + t[1] * r[1][i] + t[2] * r[2][i];
      if (abs_l(proj) > ra + rb) sep = 1;
    end
    for (int i = 0; i < 3; i++) begin
      i1 = (i + 1) % 3; i2 = (i + 2) % 3;
      for (int j = 0; j < 3; j++) begin
        j1 = (j + 1) % 3; j2 = (j + 2) % 3;
        ra = ha[i1] * ar[i2][j] + ha[i2] * ar[i1][j];
        rb = hb[j1] * ar[i][j2] + hb[j2] * ar[i][j1];
        proj = t[i1] * r[i2][j] - t[i2] * r[i1][j];
        if (abs_l(proj) > ra + rb) sep = 1;
      end
    end
    return !sep;
  endfunction

  function automatic field_t pack3(longint x, longint y, longint z);
    field_t w;
    w = '0;
    w[0 +: CB] = x[CB-1:0];
    w[CB +: CB] = y[CB-1:0];
    w[2*CB +: CB] = z[CB-1:0];
    return w;
  endfunction

  function automatic field_t rand_field();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[obb_pkg::FieldW-1:0];
  endfunction

  function automatic pair_t rand_raw_pair();
    pair_t p;
    p.ac = rand_field(); p.aax = rand_field(); p.aay = rand_field();
    p.aaz = rand_field(); p.ah = rand_field(); p.bc = rand_field();
    p.bax = rand_field(); p.bay = rand_field(); p.baz = rand_field();
    p.bh = rand_field();
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    pair_q <= p;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    overlap_q = {overlap_q, boxes_overlap(p)};
    @(negedge clk_i);
  endtask

  always @(negedge clk_i)
    overlap_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (overlap_valid_o && overlap_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
      if (overlap_valid_o && overlap_ready_i) begin
        if (overlap_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected overlap item %0b", overlap_o);
        end else begin
          bit want;
          want = overlap_q.pop_front();
          if (overlap_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("overlap mismatch: expected %0b actual %0b", want, overlap_o);
          end
        end
      end
    end
  end

  function automatic pair_t unit_pair(longint dx, longint h);
    pair_t p;
    p.ac = pack3(0, 0, 0);
    p.aax = pack3(65536, 0, 0); p.aay = pack3(0, 65536, 0); p.aaz = pack3(0, 0, 65536);
    p.bax = p.aax; p.bay = p.aay; p.baz = p.aaz;
    p.ah = pack3(h, h, h); p.bh = p.ah;
    p.bc = pack3(dx, 0, 0);
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    send_pair(unit_pair(0, 256));
    send_pair(unit_pair(512, 256));
    send_pair(unit_pair(513, 256));
    send_pair(unit_pair(511, 256));
    p = unit_pair(100, 256); p.ah = pack3(-256, -1, -131072); send_pair(p);
    p = unit_pair(100, 256); p.bh = pack3(131071, 131071, 131071); send_pair(p);
    p = unit_pair(0, 0); p.ac = pack3(131071, -131072, 0); send_pair(p);
    p = unit_pair(0, 0); p.bc = pack3(-131072, 131071, -131072); send_pair(p);
    p = unit_pair(300, 256);
    p.bax = pack3(46341, 46341, 0); p.bay = pack3(-46341, 46341, 0); send_pair(p);
    p = unit_pair(300, 100); p.bax = '0; p.aay = '0; send_pair(p);
    p = unit_pair(0, 256); p.aax = pack3(-131072, -131072, -131072);
    p.bax = pack3(131071, 131071, 131071); send_pair(p);
    send_pair('1);
    send_pair('0);
    for (int i = 0; i < 10; i++) send_pair(rand_raw_pair());
  endtask

  function automatic longint srand(int m);
    return longint'($urandom_range(2 * m)) - m;
  endfunction

  function automatic longint urand(int m);
    return longint'($urandom_range(m));
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    case ($urandom_range(3))
      0: begin
        p = rand_raw_pair();
      end
      default: begin
        p = unit_pair(0, 0);
        p.ac = pack3(srand(2000), srand(2000), srand(2000));
        p.bc = pack3(srand(2000), srand(2000), srand(2000));
        p.ah = pack3(urand(800), urand(800), urand(800));
        p.bh = pack3(urand(800), urand(800), urand(800));
        p.bax = pack3(srand(65536), srand(65536), srand(65536));
        p.bay = pack3(srand(65536), srand(65536), srand(65536));
        p.baz = pack3(srand(65536), srand(65536), srand(65536));
        if ($urandom_range(1)) begin
          p.aax = pack3(srand(65536), srand(65536), srand(65536));
          p.aay = pack3(srand(65536), srand(65536), srand(65536));
          p.aaz = pack3(srand(65536), srand(65536), srand(65536));
        end
      end
    endcase
    return p;
  endfunction

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 58;
    test_directed();
    test_random(600, 38, 58);
    test_random(600, 58, 38);
    test_random(600, 0, 0);
    in_valid_i <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
